// ===== rtl/nmeacf_pkg.sv =====
`default_nettype none

package nmeacf_pkg;

	// ascii codes the parser reacts to
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_W    = 8'h57;

	localparam int FRACTION_DIGITS_DEF = 4;

	// result scaling: 1e-7 degree units
	localparam int SCALE_DIGITS = 7;
	localparam int DEG_W        = 8;
	localparam int MIN_W        = 7;
	localparam int OUT_W        = 33;
	localparam int DEGP_W       = 32;
	localparam int N_W          = 30;
	localparam int X_W          = N_W - 2;
	localparam int RECIP_W      = 29;
	localparam int PROD_W       = X_W + RECIP_W;
	localparam int RECIP_SHIFT  = 32;
	localparam int Q_W          = PROD_W - RECIP_SHIFT;

	localparam logic [DEGP_W-1:0]  DEG_SCALE    = 32'd10_000_000;
	localparam logic [N_W-1:0]     MINUTE_ROUND = 30'd30;
	// ceil(2^32 / 15), exact for quotients of values below 2^28
	localparam logic [RECIP_W-1:0] RECIP_15     = 29'd286331154;

	function automatic logic [31:0] pow10(input int unsigned n);
		logic [31:0] r;
		r = 32'd1;
		for (int i = 0; i < 10; i++) begin
			if (i < n) begin
				r = r * 32'd10;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nmea_coordinate_field_parser.sv =====
// the end character loads parser stage s1, then scaler stages s2, s3 and the output register
// throughput: one character word per cycle while char_stall is low; the pipeline holds
// up to four coordinates, one in the parser and three in the scaler
// char_stall rises only when every pipeline stage is full and the output word is stalled
// arst_n clears the parse state and all valid flags; data registers are not reset
`default_nettype none

module nmea_coordinate_field_parser #(
	parameter int FRACTION_DIGITS = nmeacf_pkg::FRACTION_DIGITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// character words, one ascii code each
	input  wire logic                            char_valid,
	output logic                                 char_stall,
	input  wire logic [7:0]                      char_code,
	input  wire logic                            field_end,
	// coordinate words in 1e-7 degree
	output logic                                 coord_valid,
	input  wire logic                            coord_stall,
	output logic signed [nmeacf_pkg::OUT_W-1:0]  degrees_e7
);
	import nmeacf_pkg::*;

	// kept fraction digits need this many bits
	localparam int FRAC_W = $clog2(10 ** FRACTION_DIGITS);

	// parsed field handed from the character parser to the scaler
	logic               item_valid;
	logic               item_ready;
	logic [DEG_W-1:0]   item_deg;
	logic [MIN_W-1:0]   item_mint;
	logic [FRAC_W-1:0]  item_frac;
	logic               item_neg;

	// per character: digit window, fraction accumulation, hemisphere mark;
	// at field end the parsed values are registered and the state cleared
	nmeacf_parse #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.FRAC_W          (FRAC_W)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.field_end  (field_end),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_deg   (item_deg),
		.item_mint  (item_mint),
		.item_frac  (item_frac),
		.item_neg   (item_neg)
	);

	// degrees * 1e7 plus minutes / 60 rounded to nearest, then sign;
	// constant scaling, reciprocal multiply and final add each get a stage
	nmeacf_scale #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.FRAC_W          (FRAC_W)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item_deg    (item_deg),
		.item_mint   (item_mint),
		.item_frac   (item_frac),
		.item_neg    (item_neg),
		.coord_valid (coord_valid),
		.coord_stall (coord_stall),
		.degrees_e7  (degrees_e7)
	);

endmodule

`default_nettype wire

// ===== rtl/nmeacf_parse.sv =====
`default_nettype none

module nmeacf_parse #(
	parameter int FRACTION_DIGITS = nmeacf_pkg::FRACTION_DIGITS_DEF,
	parameter int FRAC_W          = $clog2(10 ** FRACTION_DIGITS)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         char_valid,
	output logic                              char_stall,
	input  wire logic [7:0]                   char_code,
	input  wire logic                         field_end,
	output logic                              item_valid,
	input  wire logic                         item_ready,
	output logic [nmeacf_pkg::DEG_W-1:0]      item_deg,
	output logic [nmeacf_pkg::MIN_W-1:0]      item_mint,
	output logic [FRAC_W-1:0]                 item_frac,
	output logic                              item_neg
);
	import nmeacf_pkg::*;

	localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);

	typedef enum logic [2:0] {
		PH_INT  = 3'b001,
		PH_FRAC = 3'b010,
		PH_HEMI = 3'b100
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [DEG_W-1:0]   deg_q, deg_n;
	logic [3:0]         tens_q, tens_n;
	logic [3:0]         units_q, units_n;
	logic [FRAC_W-1:0]  frac_q, frac_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic               neg_q, neg_n;

	logic               take;
	logic               is_digit;
	logic [3:0]         dig;
	logic [11:0]        deg_wide;
	logic [FRAC_W-1:0]  frac_pad;

	logic               valid_s1;
	logic [DEG_W-1:0]   deg_s1;
	logic [MIN_W-1:0]   mint_s1;
	logic [FRAC_W-1:0]  frac_s1;
	logic               neg_s1;

	assign char_stall = valid_s1 && !item_ready;
	assign take       = char_valid && !char_stall;
	assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign dig        = 4'(char_code - CH_ZERO);
	assign deg_wide   = 12'(deg_q) * 12'd10 + 12'(tens_q);

	always_comb begin
		phase_n = phase_q;
		deg_n   = deg_q;
		tens_n  = tens_q;
		units_n = units_q;
		frac_n  = frac_q;
		cnt_n   = cnt_q;
		neg_n   = neg_q;
		unique case (phase_q)
			PH_INT: begin
				if (is_digit) begin
					deg_n   = (deg_wide > 12'd255) ? 8'hFF : deg_wide[7:0];
					tens_n  = units_q;
					units_n = dig;
				end else if (char_code == CH_DOT) begin
					phase_n = PH_FRAC;
				end else begin
					neg_n   = (char_code == CH_S) || (char_code == CH_W);
					phase_n = PH_HEMI;
				end
			end
			PH_FRAC: begin
				if (is_digit) begin
					// digits past the kept precision are dropped
					if (cnt_q < CNT_W'(FRACTION_DIGITS)) begin
						frac_n = FRAC_W'(frac_q * FRAC_W'(10) + FRAC_W'(dig));
						cnt_n  = cnt_q + 1'b1;
					end
				end else begin
					neg_n   = (char_code == CH_S) || (char_code == CH_W);
					phase_n = PH_HEMI;
				end
			end
			default: begin
				// hemisphere decided: rest of the field is ignored
			end
		endcase
	end

	// pad missing fraction digits with zeros
	assign frac_pad = FRAC_W'(32'(frac_n) * pow10(FRACTION_DIGITS - int'(cnt_n)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INT;
			deg_q    <= '0;
			tens_q   <= '0;
			units_q  <= '0;
			frac_q   <= '0;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				if (field_end) begin
					phase_q <= PH_INT;
					deg_q   <= '0;
					tens_q  <= '0;
					units_q <= '0;
					frac_q  <= '0;
					cnt_q   <= '0;
					neg_q   <= 1'b0;
				end else begin
					phase_q <= phase_n;
					deg_q   <= deg_n;
					tens_q  <= tens_n;
					units_q <= units_n;
					frac_q  <= frac_n;
					cnt_q   <= cnt_n;
					neg_q   <= neg_n;
				end
			end
			if (take && field_end) begin
				valid_s1 <= 1'b1;
			end else if (item_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && field_end) begin
			deg_s1  <= deg_n;
			mint_s1 <= MIN_W'(MIN_W'(tens_n) * MIN_W'(10) + MIN_W'(units_n));
			frac_s1 <= frac_pad;
			neg_s1  <= neg_n;
		end
	end

	assign item_valid = valid_s1;
	assign item_deg   = deg_s1;
	assign item_mint  = mint_s1;
	assign item_frac  = frac_s1;
	assign item_neg   = neg_s1;

endmodule

`default_nettype wire

// ===== rtl/nmeacf_scale.sv =====
`default_nettype none

module nmeacf_scale #(
	parameter int FRACTION_DIGITS = nmeacf_pkg::FRACTION_DIGITS_DEF,
	parameter int FRAC_W          = $clog2(10 ** FRACTION_DIGITS)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [nmeacf_pkg::DEG_W-1:0]  item_deg,
	input  wire logic [nmeacf_pkg::MIN_W-1:0]  item_mint,
	input  wire logic [FRAC_W-1:0]             item_frac,
	input  wire logic                          item_neg,
	output logic                               coord_valid,
	input  wire logic                          coord_stall,
	output logic signed [nmeacf_pkg::OUT_W-1:0] degrees_e7
);
	import nmeacf_pkg::*;

	localparam logic [N_W-1:0] MIN_SCALE  = N_W'(DEG_SCALE);
	localparam logic [N_W-1:0] FRAC_SCALE = N_W'(pow10(SCALE_DIGITS - FRACTION_DIGITS));

	logic                     valid_s2, valid_s3, valid_q;
	logic                     rdy_s2, rdy_s3, rdy_o;

	logic [N_W-1:0]           num_c, num_s2;
	logic [DEGP_W-1:0]        degp_c, degp_s2, degp_s3;
	logic                     neg_s2, neg_s3;

	logic [X_W-1:0]           x_c;
	logic [PROD_W-1:0]        prod_c;
	logic [Q_W-1:0]           q_s3;

	logic [OUT_W-1:0]         mag_c;
	logic signed [OUT_W-1:0]  deg_e7_q;

	assign rdy_o      = !valid_q || !coord_stall;
	assign rdy_s3     = !valid_s3 || rdy_o;
	assign rdy_s2     = !valid_s2 || rdy_s3;
	assign item_ready = rdy_s2;

	// minutes scaled to 1e-7, plus half of the divisor for rounding
	assign num_c  = N_W'(item_mint) * MIN_SCALE + N_W'(item_frac) * FRAC_SCALE + MINUTE_ROUND;
	assign degp_c = DEGP_W'(item_deg) * DEG_SCALE;

	// divide by 60: drop two bits, then reciprocal multiply for 15
	assign x_c    = num_s2[N_W-1:2];
	assign prod_c = PROD_W'(x_c) * PROD_W'(RECIP_15);

	assign mag_c  = OUT_W'(degp_s3) + OUT_W'(q_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (rdy_s2) begin
				valid_s2 <= item_valid;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_o) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && item_valid) begin
			num_s2  <= num_c;
			degp_s2 <= degp_c;
			neg_s2  <= item_neg;
		end
		if (rdy_s3 && valid_s2) begin
			q_s3    <= prod_c[PROD_W-1:RECIP_SHIFT];
			degp_s3 <= degp_s2;
			neg_s3  <= neg_s2;
		end
		if (rdy_o && valid_s3) begin
			deg_e7_q <= neg_s3 ? $signed(-mag_c) : $signed(mag_c);
		end
	end

	assign coord_valid = valid_q;
	assign degrees_e7  = deg_e7_q;

endmodule

`default_nettype wire

// ===== rtl/nmeacf_checker.sv =====
`default_nettype none

module nmeacf_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            char_stall,
	input  wire logic                            coord_valid,
	input  wire logic                            coord_stall,
	input  wire logic signed [nmeacf_pkg::OUT_W-1:0] degrees_e7
);

	// a waiting coordinate word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && coord_stall |=> coord_valid)
		else $error("coordinate word dropped while stalled");

	// a waiting coordinate word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && coord_stall |=> $stable(degrees_e7))
		else $error("coordinate word changed while stalled");

	// characters are held back only by a full pipeline behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> coord_valid && coord_stall)
		else $error("character stall without output back pressure");

	// 255 degrees plus 99.9999 minutes bounds every result; the assertion checks a looser bound
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid |-> (degrees_e7 <= 33'sd2716666500) && (degrees_e7 >= -33'sd2716666500))
		else $error("coordinate out of range");

	// an offered coordinate word carries defined data
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid |-> !$isunknown(degrees_e7))
		else $error("coordinate word has unknown bits");

endmodule

bind nmea_coordinate_field_parser nmeacf_checker u_nmeacf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.char_stall  (char_stall),
	.coord_valid (coord_valid),
	.coord_stall (coord_stall),
	.degrees_e7  (degrees_e7)
);

`default_nettype wire

// ===== tb/sv/nmea_coordinate_checker.sv =====
`timescale 1ns / 100ps

module nmea_coordinate_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                char_valid,
	input  wire logic                                char_stall,
	input  wire logic [7:0]                          char_code,
	input  wire logic                                field_end,
	input  wire logic                                coord_valid,
	input  wire logic                                coord_stall,
	input  wire logic signed [nmeacf_pkg::OUT_W-1:0] degrees_e7,
	input  wire logic                                end_check,
	output int                                       fail_count,
	output int                                       coords_pending,
	output int                                       coords_checked
);
	import nmeacf_pkg::*;

	typedef enum logic [1:0] {PH_INT, PH_FRAC, PH_HEMI, PH_SPARE} phase_t;

	localparam int FRAC_DIGITS = FRACTION_DIGITS_DEF;
	localparam longint unsigned FRAC_SCALE = 10 ** FRAC_DIGITS;
	localparam longint unsigned E7 = 10_000_000;

	// parse state of the field in progress
	phase_t      phase;
	logic [7:0]  deg_acc;
	logic [3:0]  min_tens;
	logic [3:0]  min_units;
	logic [13:0] frac_acc;
	logic [2:0]  frac_cnt;
	logic        neg_flag;
	logic        hemi_seen;

	logic signed [OUT_W-1:0] coord_expected[$];
	logic signed [OUT_W-1:0] want;
	bit closed;

	initial begin
		fail_count = 0;
		coords_pending = 0;
		coords_checked = 0;
		closed = 1'b0;
	end

	task automatic report(input string msg);
		$display("%0t coord check: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_parse();
		phase = PH_INT;
		deg_acc = '0;
		min_tens = '0;
		min_units = '0;
		frac_acc = '0;
		frac_cnt = '0;
		neg_flag = 1'b0;
		hemi_seen = 1'b0;
	endtask

	task automatic take_hemi(input logic [7:0] c);
		neg_flag = (c == CH_S || c == CH_W);
		hemi_seen = 1'b1;
		phase = PH_HEMI;
	endtask

	// one accepted character word; on the field end, queue the coordinate it yields
	task automatic parse_char(input logic [7:0] c, input logic last);
		logic is_digit;
		logic [3:0] d;
		logic [11:0] wide_deg;
		logic [63:0] frac;
		logic [63:0] mins;
		logic [63:0] mag;
		is_digit = (c >= CH_ZERO && c <= CH_NINE);
		d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
		case (phase)
			PH_INT: begin
				if (is_digit) begin
					wide_deg = 12'(deg_acc) * 12'd10 + 12'(min_tens);
					deg_acc = (wide_deg > 12'd255) ? 8'd255 : wide_deg[7:0];
					min_tens = min_units;
					min_units = d;
				end else if (c == CH_DOT) begin
					phase = PH_FRAC;
				end else begin
					take_hemi(c);
				end
			end
			PH_FRAC: begin
				if (is_digit) begin
					if (frac_cnt < FRAC_DIGITS) begin
						frac_acc = frac_acc * 14'd10 + 14'(d);
						frac_cnt++;
					end
				end else begin
					take_hemi(c);
				end
			end
			default: ;
		endcase
		if (last) begin
			frac = 64'(frac_acc);
			for (int k = int'(frac_cnt); k < FRAC_DIGITS; k++) begin
				frac = frac * 10;
			end
			mins = (64'(min_tens) * 10 + 64'(min_units)) * FRAC_SCALE + frac;
			mag = 64'(deg_acc) * E7 + (mins * E7 + 30 * FRAC_SCALE) / (60 * FRAC_SCALE);
			if (neg_flag) begin
				mag = -mag;
			end
			coord_expected.push_back(mag[OUT_W-1:0]);
			clear_parse();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			coord_expected.delete();
		end else begin
			if (coord_valid && !coord_stall) begin
				if (coord_expected.size() == 0) begin
					report($sformatf("coordinate word %0d with none pending", degrees_e7));
				end else begin
					want = coord_expected.pop_front();
					if (degrees_e7 !== want) begin
						report($sformatf("degrees_e7 got %0d want %0d", degrees_e7, want));
					end
					coords_checked++;
				end
			end
			if (char_valid && !char_stall) begin
				parse_char(char_code, field_end);
			end
			if (end_check && !closed) begin
				closed = 1'b1;
				if (coord_expected.size() != 0) begin
					report($sformatf("%0d coordinate words never arrived",
						coord_expected.size()));
				end
			end
			coords_pending = coord_expected.size();
		end
	end

endmodule

// ===== tb/sv/nmea_coordinate_field_parser_tb.sv =====
`timescale 1ns / 100ps

module nmea_coordinate_field_parser_tb;
	import nmeacf_pkg::*;

	// run shape
	localparam int CHAR_TARGET    = 2000;   // random character words
	localparam int QUIET_TAIL     = 300;    // last words sent with no idling on either side
	localparam int HOLD_CYCLES    = 200;    // long output hold-off to fill the pipeline
	localparam int HOLD_FIELDS    = 24;     // one-character fields streamed during the hold-off
	localparam int DRAIN_CYCLES   = 12;     // leave slack after the last word
	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all

	// hemisphere letters the block treats as positive
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_E = 8'h45;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic [7:0] char_code = 8'h00;
	logic field_end = 1'b0;
	logic coord_stall = 1'b0;
	logic char_stall;
	logic coord_valid;
	logic signed [OUT_W-1:0] degrees_e7;
	logic end_check = 1'b0;

	int fail_count;
	int coords_pending;
	int coords_checked;

	// idling control for the sender and the receiver
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit hold_req = 1'b0;
	bit hold_active = 1'b0;
	int tx_seg_left = 0;
	bit tx_gappy = 1'b0;

	int chars_sent = 0;
	int fields_sent = 0;
	int idle_cycles = 0;
	logic [7:0] field_chars[$];

	always #5 clk = ~clk;

	nmea_coordinate_field_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.field_end   (field_end),
		.coord_valid (coord_valid),
		.coord_stall (coord_stall),
		.degrees_e7  (degrees_e7)
	);

	nmea_coordinate_checker coord_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.char_code      (char_code),
		.field_end      (field_end),
		.coord_valid    (coord_valid),
		.coord_stall    (coord_stall),
		.degrees_e7     (degrees_e7),
		.end_check      (end_check),
		.fail_count     (fail_count),
		.coords_pending (coords_pending),
		.coords_checked (coords_checked)
	);

	// watchdog: any handshake on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (coord_valid && !coord_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall bursts in some stretches, none in others,
	// one long hold-off on request, and none at all in the quiet tail
	initial begin
		int seg_left = 0;
		int burst = 0;
		bit seg_gappy = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				coord_stall <= 1'b1;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				coord_stall <= 1'b0;
				hold_req = 1'b0;
				hold_active = 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(10, 80);
					seg_gappy = ($urandom_range(0, 2) != 0);
				end
				seg_left--;
				if (!rx_quiet && seg_gappy && $urandom_range(0, 5) == 0) begin
					burst = $urandom_range(1, 11);
					coord_stall <= 1'b1;
					repeat (burst) @(posedge clk);
					coord_stall <= 1'b0;
				end
			end
		end
	end

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_hemi();
		case ($urandom_range(0, 3))
			0: return CH_N;
			1: return CH_S;
			2: return CH_E;
			default: return CH_W;
		endcase
	endfunction

	// offer one character word and hold it until the block takes it;
	// valid stays high on return so back-to-back words need no extra step
	task automatic send_char(input logic [7:0] code, input logic last);
		int gap;
		if (tx_seg_left == 0) begin
			tx_seg_left = $urandom_range(10, 80);
			tx_gappy = ($urandom_range(0, 2) != 0);
		end
		tx_seg_left--;
		if (!tx_quiet && tx_gappy && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= code;
		field_end <= last;
		do @(posedge clk); while (char_stall);
		chars_sent++;
	endtask

	// field end flag rides on the last character
	task automatic send_field();
		for (int i = 0; i < field_chars.size(); i++) begin
			send_char(field_chars[i], i == field_chars.size() - 1);
		end
		fields_sent++;
	endtask

	task automatic queue_text(input string s);
		field_chars.delete();
		for (int i = 0; i < s.len(); i++) begin
			field_chars.push_back(s[i]);
		end
	endtask

	// drop valid, then hold off until the checker has nothing outstanding
	task automatic wait_all_coords();
		char_valid <= 1'b0;
		@(posedge clk);
		wait (coords_pending == 0);
		@(posedge clk);
	endtask

	// mostly well-formed ddmm.mmmm / dddmm.mmmm fields, some broken, some pure noise
	task automatic make_field();
		int kind;
		int n_int;
		int n_frac;
		kind = $urandom_range(0, 9);
		field_chars.delete();
		if (kind == 0) begin
			// noise: arbitrary bytes, field end on whatever comes last
			repeat ($urandom_range(1, 12)) field_chars.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n_int = (kind < 8) ? $urandom_range(4, 5) : $urandom_range(0, 8);
		n_frac = (kind < 7) ? 4 : $urandom_range(0, 7);
		repeat (n_int) field_chars.push_back(rand_digit());
		if (kind < 8 || $urandom_range(0, 2) != 0) begin
			field_chars.push_back(CH_DOT);
			repeat (n_frac) field_chars.push_back(rand_digit());
			// broken: a second decimal point
			if (kind >= 8 && $urandom_range(0, 3) == 0) begin
				field_chars.push_back(CH_DOT);
			end
		end
		// hemisphere letter, or for broken fields any byte or none at all
		if (kind < 8) begin
			field_chars.push_back(rand_hemi());
		end else if ($urandom_range(0, 3) != 0) begin
			field_chars.push_back(8'($urandom_range(0, 255)));
		end
		// trailing junk after the hemisphere mark
		if (kind >= 8 && $urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 4)) field_chars.push_back(8'($urandom_range(0, 255)));
		end
		if (field_chars.size() == 0) begin
			field_chars.push_back(rand_hemi());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed fields
		// degree saturation, minutes above 59, largest magnitude, west is negative
		queue_text("99999.9999W");
		send_field();
		// second decimal point taken as the hemisphere, the digit after it ignored
		queue_text("5.1.2");
		send_field();
		// extra fraction digits dropped, no hemisphere letter before the end
		queue_text("3.12345");
		send_field();
		// no decimal point, south is negative
		queue_text("7S");
		send_field();
		// digitless field ending on the top code
		field_chars.delete();
		field_chars.push_back(8'hFF);
		send_field();
		// single zero digit, field ends on the null code
		queue_text("0");
		field_chars.push_back(8'h00);
		send_field();
		wait_all_coords();

		// long output hold-off while words keep coming: the pipeline fills and
		// char_stall must push back without losing or duplicating anything
		hold_req = 1'b1;
		wait (hold_active);
		tx_quiet = 1'b1;
		repeat (HOLD_FIELDS) begin
			field_chars.delete();
			field_chars.push_back(rand_digit());
			send_field();
		end
		tx_quiet = 1'b0;
		wait_all_coords();

		// random fields; idling stops on both sides for the tail
		while (chars_sent < CHAR_TARGET) begin
			if (chars_sent > CHAR_TARGET - QUIET_TAIL) begin
				tx_quiet = 1'b1;
				rx_quiet = 1'b1;
			end else if ($urandom_range(0, 99) == 0) begin
				// occasional full drain between fields
				wait_all_coords();
			end
			make_field();
			send_field();
		end

		// drain, give the pipeline its latency, then close out the checker
		char_valid <= 1'b0;
		@(posedge clk);
		wait (coords_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);

		$display("sent %0d character words in %0d fields, %0d coordinate words compared",
			chars_sent, fields_sent, coords_checked);
		$display("covered edge fields, a %0d-cycle output hold-off and random idling both sides",
			HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/nmeacf_pkg.sv
rtl/nmeacf_parse.sv
rtl/nmeacf_scale.sv
rtl/nmea_coordinate_field_parser.sv
rtl/nmeacf_checker.sv
tb/sv/nmea_coordinate_checker.sv
tb/sv/nmea_coordinate_field_parser_tb.sv
